@@ hdl/y2bgr_pkg.sv @@
`default_nettype none

package y2bgr_pkg;

    localparam int unsigned CHAN_W = 8;
    localparam int unsigned FRAC_BITS = 16;
    // Wide enough for every signed Q16 sum (about +/-28e6).
    localparam int unsigned SUM_W = 28;

    localparam int unsigned IN_DATA_W = 4 * CHAN_W;
    localparam int unsigned OUT_DATA_W = 6 * CHAN_W;

    localparam logic signed [SUM_W-1:0] GAIN_LUMA = SUM_W'(76309);
    localparam logic signed [SUM_W-1:0] GAIN_CHROMA = SUM_W'(74607);
    localparam logic signed [SUM_W-1:0] GAIN_G_FROM_V = SUM_W'(37974);
    localparam logic signed [SUM_W-1:0] GAIN_G_FROM_U = SUM_W'(14324);

    localparam logic signed [CHAN_W:0] LUMA_OFFSET = (CHAN_W + 1)'(16);
    localparam logic signed [CHAN_W:0] CHROMA_OFFSET = (CHAN_W + 1)'(128);

    localparam logic [CHAN_W-1:0] CHAN_MAX = '1;

    typedef struct packed {
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] blue;
    } pixel_t;

    // Drop the fraction of a positive sum and saturate at CHAN_MAX; negative and zero give black.
    function automatic logic [CHAN_W-1:0] clamp_channel(
        input logic signed [SUM_W-1:0] sum
    );
        logic [SUM_W-FRAC_BITS-1:0] whole;
        whole = sum[SUM_W-1:FRAC_BITS];
        if (sum <= 0)
            return '0;
        else if (whole > (SUM_W - FRAC_BITS)'(CHAN_MAX))
            return CHAN_MAX;
        else
            return whole[CHAN_W-1:0];
    endfunction

    function automatic logic signed [CHAN_W:0] remove_offset(
        input logic [CHAN_W-1:0] value,
        input logic signed [CHAN_W:0] offset
    );
        return signed'({1'b0, value}) - offset;
    endfunction

    function automatic pixel_t convert_pixel(
        input logic signed [CHAN_W:0] yd,
        input logic signed [CHAN_W:0] ud,
        input logic signed [CHAN_W:0] vd
    );
        logic signed [SUM_W-1:0] ys;
        logic signed [SUM_W-1:0] ue;
        logic signed [SUM_W-1:0] ve;
        pixel_t px;
        ue = SUM_W'(ud);
        ve = SUM_W'(vd);
        ys = SUM_W'(yd) * GAIN_LUMA;
        px.red = clamp_channel(ys + GAIN_CHROMA * ve);
        px.green = clamp_channel(ys - GAIN_G_FROM_V * ve - GAIN_G_FROM_U * ue);
        px.blue = clamp_channel(ys + GAIN_CHROMA * ue);
        return px;
    endfunction

endpackage

`default_nettype wire

@@ hdl/yuyv_to_bgr24_convert.sv @@
// YUYV 4:2:2 to BGR24 converter.
// Input channel (s_axis): one YUYV word per item. tdata carries Y0, Y1, U, V
// from the lowest byte up; tlast marks the last word of a frame.
// Output channel (m_axis): one item per input item, holding two BGR24
// pixels that share the word's chroma. tdata carries B0, G0, R0, B1, G1, R1
// from the lowest byte up; tlast is the input tlast, passed through.
// Each channel is a Q16 sum of offset-removed Y/U/V times fixed gains,
// truncated toward zero and clamped to 0..255.
// An accepted item passes through the input register, then the result
// register, before it is presented on m_axis.
// Throughput: one item per clock while the receiver holds m_axis_tready high,
// set by the single-pass datapath between the two registers.
// Reset clears both valid flags; no item is in flight afterwards.
// When the receiver stalls, the result register holds and the input
// register still takes one more item; s_axis_tready drops only when both
// are full.
`default_nettype none

module yuyv_to_bgr24_convert
    import y2bgr_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,

    input  wire logic                  s_axis_tvalid,
    output      logic                  s_axis_tready,
    // luma_first, luma_second, chroma_blue, chroma_red
    input  wire logic [IN_DATA_W-1:0]  s_axis_tdata,
    input  wire logic                  s_axis_tlast,

    output      logic                  m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    // blue_first, green_first, red_first, blue_second, green_second, red_second
    output      logic [OUT_DATA_W-1:0] m_axis_tdata,
    output      logic                  m_axis_tlast
);

    logic                  in_valid_reg;
    logic                  in_valid_next;
    logic [IN_DATA_W-1:0]  in_data_reg;
    logic                  in_last_reg;

    logic                  out_valid_reg;
    logic                  out_valid_next;
    logic [OUT_DATA_W-1:0] out_data_reg;
    logic [OUT_DATA_W-1:0] out_data_next;
    logic                  out_last_reg;

    logic                  out_load;
    logic                  in_load;

    logic signed [CHAN_W:0] y0_d;
    logic signed [CHAN_W:0] y1_d;
    logic signed [CHAN_W:0] u_d;
    logic signed [CHAN_W:0] v_d;
    pixel_t                 px_first;
    pixel_t                 px_second;

    // Advance the input register into the result register when the result
    // slot is free or being emptied this cycle.
    assign out_load = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || out_load;
    assign in_load = s_axis_tvalid && s_axis_tready;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (in_load)
            in_valid_next = 1'b1;
        else if (out_load)
            in_valid_next = 1'b0;

        out_valid_next = out_valid_reg;
        if (out_load)
            out_valid_next = 1'b1;
        else if (m_axis_tready)
            out_valid_next = 1'b0;
    end

    always_comb
    begin
        y0_d = remove_offset(in_data_reg[0*CHAN_W +: CHAN_W], LUMA_OFFSET);
        y1_d = remove_offset(in_data_reg[1*CHAN_W +: CHAN_W], LUMA_OFFSET);
        u_d = remove_offset(in_data_reg[2*CHAN_W +: CHAN_W], CHROMA_OFFSET);
        v_d = remove_offset(in_data_reg[3*CHAN_W +: CHAN_W], CHROMA_OFFSET);
        px_first = convert_pixel(y0_d, u_d, v_d);
        px_second = convert_pixel(y1_d, u_d, v_d);
        out_data_next = {px_second.red, px_second.green, px_second.blue,
                         px_first.red, px_first.green, px_first.blue};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_load)
        begin
            in_data_reg <= s_axis_tdata;
            in_last_reg <= s_axis_tlast;
        end
        if (out_load)
        begin
            out_data_reg <= out_data_next;
            out_last_reg <= in_last_reg;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata = out_data_reg;
    assign m_axis_tlast = out_last_reg;

endmodule

`default_nettype wire

@@ tb/testbench.sv @@
`timescale 1ns / 1ps

module testbench;

    import y2bgr_pkg::CHAN_W;
    import y2bgr_pkg::IN_DATA_W;
    import y2bgr_pkg::OUT_DATA_W;

    localparam longint GAIN_Y = 76309;
    localparam longint GAIN_C = 74607;
    localparam longint GAIN_GV = 37974;
    localparam longint GAIN_GU = 14324;
    localparam longint Y_BLACK = 16;
    localparam longint C_ZERO = 128;
    localparam int Q_SHIFT = 16;
    localparam int RANDOM_WORDS = 400;
    localparam int STALL_LIMIT = 5000;
    localparam int DRAIN_CYCLES = 8;

    typedef struct packed {
        logic frame_end;
        logic [CHAN_W-1:0] chroma_red;
        logic [CHAN_W-1:0] chroma_blue;
        logic [CHAN_W-1:0] luma_second;
        logic [CHAN_W-1:0] luma_first;
    } yuyv_word_t;

    typedef struct packed {
        logic frame_end;
        logic [CHAN_W-1:0] red_second;
        logic [CHAN_W-1:0] green_second;
        logic [CHAN_W-1:0] blue_second;
        logic [CHAN_W-1:0] red_first;
        logic [CHAN_W-1:0] green_first;
        logic [CHAN_W-1:0] blue_first;
    } bgr_pair_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic s_axis_tvalid = 1'b0;
    logic s_axis_tready;
    // luma_first, luma_second, chroma_blue, chroma_red
    logic [IN_DATA_W-1:0] s_axis_tdata = '0;
    logic s_axis_tlast = 1'b0;

    logic m_axis_tvalid;
    logic m_axis_tready = 1'b0;
    // blue_first, green_first, red_first, blue_second, green_second, red_second
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic m_axis_tlast;

    yuyv_word_t pending_words[$];
    bgr_pair_t expected_pairs[$];
    yuyv_word_t word_on_bus;
    int send_gap = 0;
    int send_run = 0;
    int stall_left = 0;
    int stall_run = 0;
    int idle_cycles = 0;
    int error_count = 0;

    yuyv_to_bgr24_convert i_dut (
        .clk(clk),
        .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .s_axis_tlast(s_axis_tlast),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .m_axis_tlast(m_axis_tlast)
    );

    always #1 clk = ~clk;

    // Drop the Q16 fraction toward zero, then saturate to a byte.
    function automatic logic [CHAN_W-1:0] q16_to_channel(input longint sum);
        if (sum <= 0)
            return '0;
        else if ((sum >>> Q_SHIFT) > 255)
            return 8'd255;
        else
            return CHAN_W'(sum >>> Q_SHIFT);
    endfunction

    function automatic bgr_pair_t yuyv_to_bgr_pair(input yuyv_word_t w);
        longint ud;
        longint vd;
        longint y0s;
        longint y1s;
        bgr_pair_t p;
        ud = longint'(w.chroma_blue) - C_ZERO;
        vd = longint'(w.chroma_red) - C_ZERO;
        y0s = GAIN_Y * (longint'(w.luma_first) - Y_BLACK);
        y1s = GAIN_Y * (longint'(w.luma_second) - Y_BLACK);
        p.red_first = q16_to_channel(y0s + GAIN_C * vd);
        p.green_first = q16_to_channel(y0s - GAIN_GV * vd - GAIN_GU * ud);
        p.blue_first = q16_to_channel(y0s + GAIN_C * ud);
        p.red_second = q16_to_channel(y1s + GAIN_C * vd);
        p.green_second = q16_to_channel(y1s - GAIN_GV * vd - GAIN_GU * ud);
        p.blue_second = q16_to_channel(y1s + GAIN_C * ud);
        p.frame_end = w.frame_end;
        return p;
    endfunction

    // Mostly short gaps, a few long ones, and now and then a run with none.
    function automatic int pick_gap(inout int no_gap_left);
        int r;
        if (no_gap_left > 0)
        begin
            no_gap_left--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 2)
        begin
            no_gap_left = $urandom_range(20, 60);
            return 0;
        end
        else if (r < 50)
            return 0;
        else if (r < 85)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 8);
        else
            return $urandom_range(15, 40);
    endfunction

    function automatic logic [CHAN_W-1:0] pick_byte();
        logic [CHAN_W-1:0] corners[6];
        corners = '{8'd0, 8'd16, 8'd128, 8'd235, 8'd240, 8'd255};
        if ($urandom_range(0, 7) == 0)
            return corners[$urandom_range(0, 5)];
        return CHAN_W'($urandom_range(0, 255));
    endfunction

    function automatic yuyv_word_t make_word(input int y0, input int y1, input int u,
                                             input int v, input bit last);
        yuyv_word_t w;
        w.luma_first = CHAN_W'(y0);
        w.luma_second = CHAN_W'(y1);
        w.chroma_blue = CHAN_W'(u);
        w.chroma_red = CHAN_W'(v);
        w.frame_end = last;
        return w;
    endfunction

    task automatic check_channel(input string name, input logic [CHAN_W-1:0] exp_val,
                                 input logic [CHAN_W-1:0] act_val);
        if (act_val !== exp_val)
        begin
            $error("%s: expected %0d, got %0d", name, exp_val, act_val);
            error_count++;
        end
    endtask

    // Sender: hold the item until taken, then insert a gap or advance.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_axis_tvalid && s_axis_tready)
                expected_pairs.push_back(yuyv_to_bgr_pair(word_on_bus));
            if (!s_axis_tvalid || s_axis_tready)
            begin
                if (send_gap > 0)
                begin
                    send_gap--;
                    s_axis_tvalid <= 1'b0;
                end
                else if (pending_words.size() > 0)
                begin
                    word_on_bus = pending_words.pop_front();
                    s_axis_tdata <= {word_on_bus.chroma_red, word_on_bus.chroma_blue,
                                     word_on_bus.luma_second, word_on_bus.luma_first};
                    s_axis_tlast <= word_on_bus.frame_end;
                    s_axis_tvalid <= 1'b1;
                    send_gap = pick_gap(send_run);
                end
                else
                    s_axis_tvalid <= 1'b0;
            end
        end
    end

    // Receiver back-pressure.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (stall_left > 0)
            begin
                stall_left--;
                m_axis_tready <= 1'b0;
            end
            else
            begin
                stall_left = pick_gap(stall_run);
                m_axis_tready <= (stall_left == 0);
            end
        end
    end

    always @(posedge clk)
    begin
        bgr_pair_t got;
        bgr_pair_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got = {m_axis_tlast, m_axis_tdata};
            if (expected_pairs.size() == 0)
            begin
                $error("unexpected pixel pair %h", got);
                error_count++;
            end
            else
            begin
                want = expected_pairs.pop_front();
                check_channel("blue_first", want.blue_first, got.blue_first);
                check_channel("green_first", want.green_first, got.green_first);
                check_channel("red_first", want.red_first, got.red_first);
                check_channel("blue_second", want.blue_second, got.blue_second);
                check_channel("green_second", want.green_second, got.green_second);
                check_channel("red_second", want.red_second, got.red_second);
                check_channel("frame_end_out", CHAN_W'(want.frame_end),
                              CHAN_W'(got.frame_end));
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("testbench: done, errors");
            $finish;
        end
    end

    initial
    begin
        int luma_corners[4];
        int chroma_corners[3];
        int frame_left;
        luma_corners = '{0, 16, 235, 255};
        chroma_corners = '{0, 128, 255};

        // Corners: black/white luma against zero, mid-scale and full-scale chroma both ways.
        foreach (luma_corners[i])
            foreach (chroma_corners[j])
                pending_words.push_back(make_word(luma_corners[i], 255 - luma_corners[i],
                                                  chroma_corners[j],
                                                  255 - chroma_corners[j],
                                                  chroma_corners[j] == 255));
        // Sums of exactly zero give black.
        pending_words.push_back(make_word(16, 16, 128, 128, 1'b0));
        pending_words.push_back(make_word(235, 235, 240, 16, 1'b1));
        pending_words.push_back(make_word(81, 145, 90, 240, 1'b0));
        pending_words.push_back(make_word(255, 0, 16, 240, 1'b0));
        pending_words.push_back(make_word(128, 128, 255, 255, 1'b1));
        pending_words.push_back(make_word(255, 255, 0, 0, 1'b0));

        frame_left = $urandom_range(1, 16);
        repeat (RANDOM_WORDS)
        begin
            frame_left--;
            pending_words.push_back(make_word(pick_byte(), pick_byte(), pick_byte(),
                                              pick_byte(), frame_left == 0));
            if (frame_left == 0)
                frame_left = $urandom_range(1, 16);
        end

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        while (pending_words.size() > 0 || s_axis_tvalid)
            @(posedge clk);
        while (expected_pairs.size() > 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (error_count == 0)
            $display("testbench: done, clean");
        else
            $display("testbench: done, errors");
        $finish;
    end

endmodule

@@ filelist.f @@
hdl/y2bgr_pkg.sv
hdl/yuyv_to_bgr24_convert.sv
tb/testbench.sv
